>>> rtl/pvdg_pkg.sv
// Shared types and constants for the pump, valve and direction guard block.
// No dependencies; imported by pvdg_eval and pump_valve_direction_guard_pwm_top.
package pvdg_pkg;

  localparam int unsigned US_PER_MS = 1000;
  localparam int unsigned PRESC_W   = (US_PER_MS > 1) ? $clog2(US_PER_MS) : 1;

  localparam logic [15:0] GUARD_MS_RESET  = 16'd200;
  localparam logic [15:0] PWM_PERIOD_RESET = 16'd20000;
  localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;
  localparam logic [7:0]  DUTY_FULL       = 8'd255;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_BITS  = 2'd1,
    OP_REQ   = 2'd2,
    OP_ESTOP = 2'd3
  } op_t;

  localparam logic [1:0] MODE_STOP    = 2'd0;
  localparam logic [1:0] MODE_ASCEND  = 2'd1;
  localparam logic [1:0] MODE_DESCEND = 2'd2;
  localparam logic [1:0] MODE_BALANCE = 2'd3;

  localparam logic [0:0] CFG_GUARD_MS   = 1'd0;
  localparam logic [0:0] CFG_PWM_PERIOD = 1'd1;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] actuator_bits;
    logic [1:0] direction;
    logic [7:0] level;
  } item_t;

  typedef struct packed {
    logic [5:0]         drive_latch;
    logic [1:0]         req_mode;
    logic [7:0]         req_level;
    logic [1:0]         app_mode;
    logic [7:0]         app_level;
    logic [15:0]        elapsed_ms;
    logic [PRESC_W-1:0] us_presc;
    logic [15:0]        period_pos;
    logic [1:0]         valves;
  } state_t;

  typedef struct packed {
    logic [7:0] applied_level;
    logic [1:0] applied_direction;
    logic       valve_f;
    logic       valve_e;
    logic       pump_on;
    logic [5:0] drive_bits;
  } result_t;

endpackage

>>> rtl/pump_valve_direction_guard_pwm_top.sv
// Top level of the buoyancy pump and valve driver with direction guard and PWM.
// Depends on pvdg_pkg and pvdg_eval.
// The input register feeds the single evaluation stage; its state and result are registered.
// Throughput: one transaction per cycle unless out_tready is low with a result waiting.
// Reset: synchronous active-low rst_n clears all state and valid flags and loads
// guard_ms = 200 and pwm_period_us = 20000; the block accepts items right after reset.
module pump_valve_direction_guard_pwm_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // actuator_bits[5:0], direction[7:6], level[15:8]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // drive_bits[5:0], pump_on[6], valve_e[7], valve_f[8],
                                  // applied_direction[10:9], applied_level[18:11], zero
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pvdg_pkg::*;

  logic        s1_valid_r;
  item_t       s1_item_r;
  logic        out_valid_r;
  result_t     out_res_r;
  state_t      st_r;
  state_t      st_nxt;
  result_t     res_nxt;
  logic [15:0] guard_ms_r;
  logic [15:0] pwm_period_r;
  logic        advance;

  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = advance || !s1_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r};

  pvdg_eval u_eval (
    .item          (s1_item_r),
    .cur           (st_r),
    .guard_ms      (guard_ms_r),
    .pwm_period_us (pwm_period_r),
    .nxt           (st_nxt),
    .res           (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guard_ms_r   <= GUARD_MS_RESET;
      pwm_period_r <= PWM_PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GUARD_MS:   guard_ms_r   <= cfg_data;
        CFG_PWM_PERIOD: pwm_period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          st_r <= st_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= {in_tuser, in_tdata[5:0], in_tdata[7:6], in_tdata[15:8]};
    end
    if (advance && s1_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while both stages are full and stalled");

  a_presc_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, st_r.us_presc} < (PRESC_W+1)'(US_PER_MS)))
    else $error("microsecond prescaler out of range");

  a_pump_one_valve: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.pump_on) |->
      (out_res_r.valve_e != out_res_r.valve_f && out_res_r.applied_level != 8'd0))
    else $error("pump running without a single open valve");

  a_balance_outputs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.applied_direction == MODE_BALANCE) |->
      (out_res_r.valve_e && out_res_r.valve_f && !out_res_r.pump_on &&
       out_res_r.applied_level == 8'd0))
    else $error("balance mode outputs inconsistent");

  a_result_follows_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance) |=> out_valid_r)
    else $error("evaluated transaction lost");

endmodule

>>> rtl/pvdg_eval.sv
// Next-state and result logic for one transaction of the pump and valve driver.
// Depends on pvdg_pkg.
module pvdg_eval (
  input  pvdg_pkg::item_t  item,
  input  pvdg_pkg::state_t cur,
  input  logic [15:0]      guard_ms,
  input  logic [15:0]      pwm_period_us,
  output pvdg_pkg::state_t nxt,
  output pvdg_pkg::result_t res
);
  import pvdg_pkg::*;

  state_t      s;
  logic [16:0] pos_inc;
  logic [16:0] pos_ref;
  logic [24:0] on_lhs;
  logic [24:0] on_rhs;
  logic        pump;

  always_comb begin
    s       = cur;
    pump    = 1'b0;
    pos_inc = {1'b0, cur.period_pos} + 17'd1;
    pos_ref = 17'd0;
    on_lhs  = 25'd0;
    on_rhs  = 25'd0;

    case (op_t'(item.op))
      OP_TICK: begin
        if ({1'b0, cur.us_presc} + 1'b1 >= (PRESC_W+1)'(US_PER_MS)) begin
          s.us_presc = '0;
          if (cur.elapsed_ms != ELAPSED_MAX) begin
            s.elapsed_ms = cur.elapsed_ms + 16'd1;
          end
        end else begin
          s.us_presc = cur.us_presc + 1'b1;
        end
        if (pos_inc >= {1'b0, pwm_period_us}) begin
          s.period_pos = '0;
        end else begin
          s.period_pos = pos_inc[15:0];
        end
      end
      OP_BITS: begin
        s.drive_latch = item.actuator_bits;
      end
      OP_REQ: begin
        if (item.direction == MODE_STOP ||
            (item.level == 8'd0 && item.direction != MODE_BALANCE)) begin
          s.req_mode  = MODE_STOP;
          s.req_level = 8'd0;
        end else begin
          s.req_mode  = item.direction;
          s.req_level = item.level;
        end
      end
      default: begin
        s.drive_latch = '0;
        s.req_mode    = MODE_STOP;
        s.req_level   = 8'd0;
        s.app_mode    = MODE_STOP;
        s.app_level   = 8'd0;
      end
    endcase

    // pump on when 255*(period_pos+1) <= level*period, i.e. period_pos+1 <= level*period/255
    pos_ref = {1'b0, s.period_pos} + 17'd1;
    on_lhs  = {pos_ref, 8'd0} - {8'd0, pos_ref};
    on_rhs  = 25'(s.req_level) * 25'(pwm_period_us);

    if (s.req_mode == MODE_STOP || s.req_level == 8'd0) begin
      s.app_mode  = MODE_STOP;
      s.app_level = 8'd0;
      s.valves    = 2'b00;
    end else if (s.req_mode == MODE_BALANCE) begin
      s.app_mode  = MODE_BALANCE;
      s.app_level = 8'd0;
      s.valves    = 2'b11;
    end else if (s.req_mode != s.app_mode && s.elapsed_ms < guard_ms) begin
      s.app_level = 8'd0;
    end else begin
      if (s.req_mode != s.app_mode) begin
        s.app_mode   = s.req_mode;
        s.elapsed_ms = '0;
      end
      s.app_level = s.req_level;
      s.valves    = (s.app_mode == MODE_ASCEND) ? 2'b01 : 2'b10;
      pump        = (on_lhs <= on_rhs);
    end

    nxt                   = s;
    res.drive_bits        = s.drive_latch;
    res.pump_on           = pump;
    res.valve_e           = s.valves[0];
    res.valve_f           = s.valves[1];
    res.applied_direction = s.app_mode;
    res.applied_level     = s.app_level;
  end

endmodule
